@@ design/rn2a_pkg.sv @@
package rn2a_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int RADIX_W        = 6;
	localparam int CHAR_W         = 7;
	localparam int APB_DATA_W     = 32;
	localparam int APB_ADDR_W     = 2;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd16;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;
	localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'd48;
	localparam logic [CHAR_W-1:0]  ASCII_A     = 7'd65;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic div_step;
		logic store;
		logic rd;
		logic ld_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_last;
		logic q_zero;
		logic cnt_zero;
	} status_t;

	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end
		return res;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DIGIT_TEN) begin
			c = CHAR_W'(d) + ASCII_ZERO;
		end else begin
			c = CHAR_W'(d) - CHAR_W'(DIGIT_TEN) + ASCII_A;
		end
		return c;
	endfunction

endpackage

@@ design/rn2a_ctrl.sv @@
module rn2a_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  rn2a_pkg::status_t status,
	output rn2a_pkg::cmd_t    cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_STORE = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_LOAD  = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       last_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_nx     = state_q;
		cmd          = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_nx = S_STORE;
				end
			end
			S_STORE: begin
				cmd.store = 1'b1;
				state_nx  = status.q_zero ? S_READ : S_DIV;
			end
			S_READ: begin
				cmd.rd   = 1'b1;
				state_nx = S_LOAD;
			end
			S_LOAD: begin
				cmd.ld_out = 1'b1;
				state_nx   = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					state_nx = last_q ? S_IDLE : S_READ;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.ld_out) begin
				last_q <= status.cnt_zero;
			end
		end
	end

endmodule

@@ design/rn2a_dp.sv @@
module rn2a_dp #(
	parameter int VALUE_BITS = rn2a_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rn2a_pkg::cmd_t                cmd,
	output rn2a_pkg::status_t             status,
	input  logic [31:0]                   value,
	input  logic [rn2a_pkg::RADIX_W-1:0]  radix_reg,
	output logic [rn2a_pkg::CHAR_W-1:0]   digit_char,
	output logic                          last
);

	localparam int CNT_W = $clog2(VALUE_BITS + 1);
	localparam int IDX_W = $clog2(VALUE_BITS);
	localparam int BIT_W = $clog2(VALUE_BITS);
	localparam int RW    = rn2a_pkg::RADIX_W;

	logic [VALUE_BITS-1:0] v_q;
	logic [RW-1:0]         rem_q;
	logic [BIT_W-1:0]      bit_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      cnt_m1;
	logic [RW-1:0]         mem [VALUE_BITS];
	logic [RW-1:0]         rd_q;
	logic [RW-1:0]         radix_e;
	logic [RW:0]           rem_sh;
	logic [RW-1:0]         rem_nx;
	logic                  q_bit;
	logic                  last_q;
	logic [rn2a_pkg::CHAR_W-1:0] char_q;

	assign radix_e = rn2a_pkg::eff_radix(radix_reg);
	assign cnt_m1  = cnt_q - 1'b1;

	// One restoring shift-subtract step of the division by the radix.
	// The new remainder is always below the radix, so it fits the radix width.
	always_comb begin
		rem_sh = {rem_q, v_q[VALUE_BITS-1]};
		q_bit  = (rem_sh >= {1'b0, radix_e});
		rem_nx = q_bit ? RW'(rem_sh - {1'b0, radix_e}) : rem_sh[RW-1:0];
	end

	assign status.div_last = (bit_q == '0);
	assign status.q_zero   = (v_q == '0);
	assign status.cnt_zero = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			bit_q <= '0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
				bit_q <= BIT_W'(VALUE_BITS - 1);
			end else if (cmd.div_step) begin
				bit_q <= bit_q - 1'b1;
			end else if (cmd.store) begin
				cnt_q <= cnt_q + 1'b1;
				bit_q <= BIT_W'(VALUE_BITS - 1);
			end else if (cmd.rd) begin
				cnt_q <= cnt_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q   <= VALUE_BITS'(value);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			v_q   <= {v_q[VALUE_BITS-2:0], q_bit};
			rem_q <= rem_nx;
		end else if (cmd.store) begin
			rem_q <= '0;
		end
		if (cmd.ld_out) begin
			char_q <= rn2a_pkg::digit_ascii(rd_q);
			last_q <= (cnt_q == '0);
		end
	end

	// Digit store: written least significant first, read back in reverse.
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[cnt_q[IDX_W-1:0]] <= rem_q;
		end
		if (cmd.rd) begin
			rd_q <= mem[cnt_m1[IDX_W-1:0]];
		end
	end

	assign digit_char = char_q;
	assign last       = last_q;

endmodule

@@ design/radix_number_to_ascii.sv @@
// Each digit costs one pass of the bit-serial shift-subtract divider and a store of its remainder,
// and each character then takes a memory read, an output load and an output state that holds
// while out_stall is high.
// One value is converted at a time: in_stall stays high until its last character is accepted.
// Reset: arst_n clears the controller to idle and sets the radix register to 16.
module radix_number_to_ascii #(
	parameter int VALUE_BITS = rn2a_pkg::VALUE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [31:0]                      value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [rn2a_pkg::CHAR_W-1:0]      digit_char,
	output logic                             last,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rn2a_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [rn2a_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [rn2a_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready
);

	logic [rn2a_pkg::RADIX_W-1:0] radix_q;
	rn2a_pkg::cmd_t               cmd;
	rn2a_pkg::status_t            status;
	logic                         unused_addr;

	assign pready      = 1'b1;
	// A single register occupies the whole address range.
	assign unused_addr = ^paddr;
	assign prdata      = {{(rn2a_pkg::APB_DATA_W - rn2a_pkg::RADIX_W){unused_addr & 1'b0}},
		radix_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rn2a_pkg::RADIX_RESET;
		end else if (psel && penable && pwrite && pready) begin
			radix_q <= pwdata[rn2a_pkg::RADIX_W-1:0];
		end
	end

	rn2a_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	rn2a_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.value      (value),
		.radix_reg  (radix_q),
		.digit_char (digit_char),
		.last       (last)
	);

endmodule

@@ design/rn2a_checker.sv @@
module rn2a_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [6:0] digit_char,
	input logic       last
);

	// A word stalled at the output stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(digit_char) && $stable(last))
		else $error("stalled output word changed");

	// While characters of one value go out, no new value is taken.
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while output busy");

	a_busy_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after taking a value");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (digit_char >= 7'd48 && digit_char <= 7'd57) ||
			(digit_char >= 7'd65 && digit_char <= 7'd90))
		else $error("output character is not a digit");

endmodule

bind radix_number_to_ascii rn2a_checker u_rn2a_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.digit_char (digit_char),
	.last       (last)
);

@@ tb/sv/radix_number_to_ascii_checker.sv @@
`timescale 1ns / 100ps

module radix_number_to_ascii_checker #(
	parameter int VALUE_BITS = rn2a_pkg::VALUE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [31:0]                     value,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [rn2a_pkg::CHAR_W-1:0]     digit_char,
	input  logic                            last,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rn2a_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rn2a_pkg::APB_DATA_W-1:0] pwdata,
	input  logic                            pready,
	output int                              fail_count,
	output int                              pending,
	output int                              values_in,
	output int                              chars_out
);

	localparam int RADIX_IDX = 0;

	typedef struct {
		logic [rn2a_pkg::CHAR_W-1:0] ch;
		logic                        last;
	} glyph_t;

	logic [rn2a_pkg::RADIX_W-1:0] radix_q;
	glyph_t                       char_queue[$];

	// Pushes the characters of one word, most significant digit first.
	function automatic void predict_chars(input logic [31:0] word);
		logic [63:0]                  rest;
		logic [63:0]                  base;
		logic [63:0]                  keep_mask;
		logic [rn2a_pkg::RADIX_W-1:0] digs [0:63];
		logic [rn2a_pkg::RADIX_W-1:0] d;
		glyph_t                       g;
		int                           n;
		int                           k;
		keep_mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
		rest = {32'b0, word} & keep_mask;
		if (radix_q < rn2a_pkg::RADIX_MIN) begin
			base = 64'(rn2a_pkg::RADIX_MIN);
		end else if (radix_q > rn2a_pkg::RADIX_MAX) begin
			base = 64'(rn2a_pkg::RADIX_MAX);
		end else begin
			base = 64'(radix_q);
		end
		n = 0;
		do begin
			digs[n] = rn2a_pkg::RADIX_W'(rest % base);
			n++;
			rest = rest / base;
		end while (rest != 0 && n < 64);
		for (k = n - 1; k >= 0; k--) begin
			d = digs[k];
			if (d < rn2a_pkg::DIGIT_TEN) begin
				g.ch = rn2a_pkg::ASCII_ZERO + rn2a_pkg::CHAR_W'(d);
			end else begin
				g.ch = rn2a_pkg::ASCII_A + rn2a_pkg::CHAR_W'(d - rn2a_pkg::DIGIT_TEN);
			end
			g.last = (k == 0);
			char_queue.push_back(g);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		glyph_t want;
		if (!arst_n) begin
			radix_q = rn2a_pkg::RADIX_RESET;
			char_queue.delete();
			fail_count = 0;
			values_in = 0;
			chars_out = 0;
		end else begin
			if (psel && penable && pwrite && pready && int'(paddr >> 2) == RADIX_IDX) begin
				radix_q = pwdata[rn2a_pkg::RADIX_W-1:0];
			end
			if (in_valid && !in_stall) begin
				predict_chars(value);
				values_in++;
			end
			if (out_valid && !out_stall) begin
				chars_out++;
				if (char_queue.size() == 0) begin
					$display("%0t: unexpected word, got char 0x%02h last=%0b",
						$time, digit_char, last);
					fail_count++;
				end else begin
					want = char_queue.pop_front();
					if (digit_char !== want.ch || last !== want.last) begin
						$display("%0t: mismatch, expected char 0x%02h last=%0b,",
							$time, want.ch, want.last);
						$display("%0t:   got char 0x%02h last=%0b",
							$time, digit_char, last);
						fail_count++;
					end
				end
			end
		end
		pending = char_queue.size();
	end

endmodule

@@ tb/sv/tb_radix_number_to_ascii.sv @@
`timescale 1ns / 100ps

module tb_radix_number_to_ascii;

	localparam int VALUE_BITS  = rn2a_pkg::VALUE_BITS_DEF;
	localparam int IDLE_LIMIT  = 20000;
	localparam int HOLD_CYCLES = 1500;
	localparam int RAND_ITEMS  = 285;
	localparam logic [rn2a_pkg::APB_ADDR_W-1:0] RADIX_ADDR = '0;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	logic [31:0]                     value;
	logic                            out_valid;
	logic                            out_stall;
	logic [rn2a_pkg::CHAR_W-1:0]     digit_char;
	logic                            last;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [rn2a_pkg::APB_ADDR_W-1:0] paddr;
	logic [rn2a_pkg::APB_DATA_W-1:0] pwdata;
	logic [rn2a_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;

	int  fail_count;
	int  pending;
	int  values_in;
	int  chars_out;
	int  radix_writes;
	int  idle_cycles;
	bit  calm;
	bit  hold_req;
	bit  held_once;

	radix_number_to_ascii #(.VALUE_BITS(VALUE_BITS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .value(value),
		.out_valid(out_valid), .out_stall(out_stall), .digit_char(digit_char), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	radix_number_to_ascii_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .value(value),
		.out_valid(out_valid), .out_stall(out_stall), .digit_char(digit_char), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .pending(pending),
		.values_in(values_in), .chars_out(chars_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: any accepted word or register access resets the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (psel && penable && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout after %0d cycles without progress", idle_cycles);
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(30, 120);
	endfunction

	// Receiver: runs of ready and stalled cycles, plus one long hold on request.
	initial begin
		int run_left;
		out_stall = 1'b0;
		held_once = 1'b0;
		run_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !held_once) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				held_once = 1'b1;
				out_stall = 1'b0;
				run_left = 0;
			end else if (calm) begin
				out_stall = 1'b0;
			end else if (run_left > 0) begin
				run_left--;
			end else begin
				run_left = pick_gap();
				out_stall = (run_left != 0);
				if (!out_stall) begin
					run_left = $urandom_range(0, 20);
				end
			end
		end
	end

	task automatic reg_write(input logic [rn2a_pkg::APB_ADDR_W-1:0] addr,
			input logic [31:0] data);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		radix_writes++;
	endtask

	task automatic send_word(input logic [31:0] v);
		int gap;
		gap = pick_gap();
		repeat (gap) @(negedge clk);
		in_valid = 1'b1;
		value = v;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Every word yields at least one character, so an empty queue means the block is idle.
	task automatic wait_drained();
		wait (pending == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_radix(input logic [31:0] data);
		wait_drained();
		reg_write(RADIX_ADDR, data);
	endtask

	function automatic logic [31:0] pick_value();
		int r;
		int k;
		r = $urandom_range(0, 9);
		k = $urandom_range(0, 31);
		case (r)
			0, 1, 2, 3: return $urandom;
			4, 5:       return $urandom >> k;
			6:          return $urandom_range(0, 40);
			7:          return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
			8:          return (32'h1 << k) - ($urandom_range(0, 1));
			default:    return ~($urandom >> k);
		endcase
	endfunction

	initial begin
		int sent;
		int seg;
		int n;
		logic [31:0] rad;
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		radix_writes = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset radix is sixteen.
		send_word(32'd0);
		send_word(32'd15);
		send_word(32'd16);
		send_word(32'hFFFF_FFFF);
		send_word(32'h8000_0000);
		set_radix(32'd10);
		send_word(32'd9);
		send_word(32'd10);
		send_word(32'hFFFF_FFFF);
		send_word(32'd1_000_000_000);
		set_radix(32'd2);
		send_word(32'd0);
		send_word(32'd1);
		send_word(32'hFFFF_FFFF);
		send_word(32'hAAAA_AAAA);
		set_radix(32'd36);
		send_word(32'd35);
		send_word(32'd36);
		send_word(32'd1295);
		send_word(32'hFFFF_FFFF);
		// Register values below two and above thirty-six saturate.
		set_radix(32'd0);
		send_word(32'd5);
		set_radix(32'd1);
		send_word(32'd6);
		set_radix(32'd37);
		send_word(32'd35);
		set_radix(32'd63);
		send_word(32'd71);
		// Only the low six bits of the written data are kept.
		set_radix(32'hFFFF_FFC8);
		send_word(32'd64);
		send_word(32'd8);

		sent = 0;
		seg = 0;
		while (sent < RAND_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				rad = {$urandom_range(0, 3) == 0 ? $urandom : 32'h0} & 32'hFFFF_FFC0;
				rad = rad | $urandom_range(0, 63);
			end else begin
				rad = $urandom_range(2, 36);
			end
			set_radix(rad);
			calm = (seg == 5);
			if (seg == 3) begin
				hold_req = 1'b1;
			end
			n = $urandom_range(15, 30);
			while (n > 0 && sent < RAND_ITEMS) begin
				send_word(pick_value());
				sent++;
				n--;
			end
			seg++;
		end
		calm = 1'b0;

		wait_drained();
		repeat (40) @(negedge clk);
		$display("Converted %0d values into %0d characters over %0d radix writes,",
			values_in, chars_out, radix_writes);
		$display("including saturating radix settings and a %0d-cycle receiver hold (done=%0b).",
			HOLD_CYCLES, held_once);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
design/rn2a_pkg.sv
design/rn2a_ctrl.sv
design/rn2a_dp.sv
design/radix_number_to_ascii.sv
design/rn2a_checker.sv
tb/sv/radix_number_to_ascii_checker.sv
tb/sv/tb_radix_number_to_ascii.sv
